// ===== hdl/morton_window_bounds_3d_unit_assert.svh =====
// Assertion macros for the Morton window bounds unit.
// Used by the checker module; needs nothing else.
`ifndef MORTON_WINDOW_BOUNDS_3D_UNIT_ASSERT_SVH
`define MORTON_WINDOW_BOUNDS_3D_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWB3D_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("mwb3d check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MWB3D_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("mwb3d check failed");

`endif

// ===== hdl/mwb3d_pkg.sv =====
// Shared types and constants for the Morton window bounds unit.
// No dependencies; the interfaces, the bounds logic, the top level and the checker import it.
`default_nettype none

package mwb3d_pkg;

	localparam int FIELD_W        = 16;
	localparam int CODE_OUT_W     = 48;
	localparam int COORD_BITS_DEF = 16;
	localparam int HALF_W         = FIELD_W - 1;

	localparam logic [FIELD_W-1:0] WINDOW_SIZE_RST = 16'd3;

	typedef struct packed {
		logic [FIELD_W-1:0] coord_x;
		logic [FIELD_W-1:0] coord_y;
		logic [FIELD_W-1:0] coord_z;
	} point_t;

	typedef struct packed {
		logic [CODE_OUT_W-1:0] window_min;
		logic [CODE_OUT_W-1:0] window_max;
	} bounds_t;

endpackage

`default_nettype wire

// ===== hdl/mwb3d_if.sv =====
// Valid/ready channel interfaces for points in and code bounds out.
// Depends on mwb3d_pkg for the field widths.
`default_nettype none

interface mwb3d_point_if import mwb3d_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] coord_x;
	logic [FIELD_W-1:0] coord_y;
	logic [FIELD_W-1:0] coord_z;

	modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
	modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface mwb3d_bounds_if import mwb3d_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CODE_OUT_W-1:0] window_min;
	logic [CODE_OUT_W-1:0] window_max;

	modport source (output valid, output window_min, output window_max, input ready);
	modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

`default_nettype wire

// ===== hdl/mwb3d_bounds.sv =====
// Combinational window corner stepping and Morton interleave for one point.
// Depends on mwb3d_pkg.
`default_nettype none

module mwb3d_bounds import mwb3d_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  var point_t              pt,
	input  wire  [HALF_W-1:0]       half,
	output logic [CODE_OUT_W-1:0]   code_lo,
	output logic [CODE_OUT_W-1:0]   code_hi
);

	// Wide enough that c + half never overflows.
	localparam int CW     = ((COORD_BITS > HALF_W) ? COORD_BITS : HALF_W) + 2;
	localparam int CODE_W = 3 * COORD_BITS;

	logic [2:0][FIELD_W-1:0]    raw;
	logic [2:0][COORD_BITS-1:0] c;
	logic [2:0][COORD_BITS-1:0] bwd;
	logic [2:0][COORD_BITS-1:0] fwd;
	logic [CW-1:0]              half_ext;
	logic [CW-1:0]              cmax_ext;
	logic [CODE_W-1:0]          lo_full;
	logic [CODE_W-1:0]          hi_full;

	assign raw      = {pt.coord_x, pt.coord_y, pt.coord_z};
	assign half_ext = CW'(half);
	assign cmax_ext = {{(CW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

	// Axis 2 is x, axis 1 is y, axis 0 is z, matching the code bit order.
	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic [CW-1:0] c_ext;
		logic [CW-1:0] sum;
		logic [CW-1:0] diff;

		if (COORD_BITS <= FIELD_W) begin : g_cut
			assign c[a] = raw[a][COORD_BITS-1:0];
		end else begin : g_ext
			assign c[a] = {{(COORD_BITS-FIELD_W){1'b0}}, raw[a]};
		end

		assign c_ext = CW'(c[a]);
		assign sum   = c_ext + half_ext;
		assign diff  = c_ext - half_ext;

		// Step only when the moved corner stays strictly inside the range.
		assign fwd[a] = (sum < cmax_ext) ? sum[COORD_BITS-1:0] : c[a];
		assign bwd[a] = (c_ext > half_ext) ? diff[COORD_BITS-1:0] : c[a];
	end

	for (genvar i = 0; i < COORD_BITS; i++) begin : g_ilv
		assign lo_full[3*i+2] = bwd[2][i];
		assign lo_full[3*i+1] = bwd[1][i];
		assign lo_full[3*i]   = bwd[0][i];
		assign hi_full[3*i+2] = fwd[2][i];
		assign hi_full[3*i+1] = fwd[1][i];
		assign hi_full[3*i]   = fwd[0][i];
	end

	if (CODE_W >= CODE_OUT_W) begin : g_trim
		assign code_lo = lo_full[CODE_OUT_W-1:0];
		assign code_hi = hi_full[CODE_OUT_W-1:0];
	end else begin : g_pad
		assign code_lo = {{(CODE_OUT_W-CODE_W){1'b0}}, lo_full};
		assign code_hi = {{(CODE_OUT_W-CODE_W){1'b0}}, hi_full};
	end

endmodule

`default_nettype wire

// ===== hdl/morton_window_bounds_3d_unit.sv =====
// Top level of the Morton window bounds unit: input and result registers.
// Depends on mwb3d_pkg, the channel interfaces in mwb3d_if and mwb3d_bounds.
//
// For each 3D point transferred in on the point channel, the unit returns one
// transfer on the bounds channel holding the least and the greatest 48-bit
// Morton code over the eight corners of a cube window centered on the point.
// The offset is window_size / 2 (rounded down); each corner coordinate moves
// by the offset only where the move stays strictly inside the coordinate
// range, otherwise it keeps the center value. A point passes the input
// register, then the result register, with the corner stepping and interleave
// between them. One point is taken every clock cycle as long as the bounds
// channel keeps accepting; the rate is set by the single result register,
// which holds its transfer while the sink stalls and lets the input register
// fill behind it. window_size resets to 3; the user writes it through
// cfg_we/cfg_wdata only while no point is in flight, unenforced by the block.
`default_nettype none

module morton_window_bounds_3d_unit import mwb3d_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire  [FIELD_W-1:0] cfg_wdata,
	mwb3d_point_if.sink        point,
	mwb3d_bounds_if.source     bounds
);

	logic [FIELD_W-1:0]    window_size_q;
	logic                  valid_s1;
	point_t                pt_s1;
	logic                  valid_s2;
	bounds_t               res_s2;
	logic                  s2_free;
	logic                  advance;
	logic [CODE_OUT_W-1:0] code_lo;
	logic [CODE_OUT_W-1:0] code_hi;

	// The result register is free when empty or when its transfer completes now.
	assign s2_free     = !valid_s2 || bounds.ready;
	assign advance     = valid_s1 && s2_free;
	assign point.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			window_size_q <= cfg_wdata;
		end
	end

	// Input register: takes a new point whenever the stage is empty or draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (point.ready) begin
			valid_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (point.valid && point.ready) begin
			pt_s1 <= '{coord_x: point.coord_x, coord_y: point.coord_y,
				coord_z: point.coord_z};
		end
	end

	// The half-width is the register shifted right by one.
	mwb3d_bounds #(
		.COORD_BITS(COORD_BITS)
	) u_bounds (
		.pt      (pt_s1),
		.half    (window_size_q[FIELD_W-1:1]),
		.code_lo (code_lo),
		.code_hi (code_hi)
	);

	// Result register: holds its codes until the sink completes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= '{window_min: code_lo, window_max: code_hi};
		end
	end

	assign bounds.valid      = valid_s2;
	assign bounds.window_min = res_s2.window_min;
	assign bounds.window_max = res_s2.window_max;

endmodule

`default_nettype wire

// ===== hdl/mwb3d_checker.sv =====
// Port-level checker for the Morton window bounds unit, bound to the top.
// Depends on morton_window_bounds_3d_unit_assert.svh for the assertion macros.
`default_nettype none

`include "morton_window_bounds_3d_unit_assert.svh"

module mwb3d_checker import mwb3d_pkg::*; (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire [CODE_OUT_W-1:0] window_min,
	input wire [CODE_OUT_W-1:0] window_max
);

	// A stalled result keeps its place and its codes.
	`MWB3D_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(window_min) && $stable(window_max))

	// The input side only stalls when both registers are full and the sink is stalled.
	`MWB3D_ASSERT_NOW(a_in_stall, clk, arst_n, !in_ready, out_valid && !out_ready)

	// A result appearing on an empty output stems from a point that passed the input register, then the result register.
	`MWB3D_ASSERT_NOW(a_latency, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

	// An unaccepted input while the output is blocked means a result is still offered on the next cycle.
	`MWB3D_ASSERT_NEXT(a_stall_cause, clk, arst_n, !in_ready && !out_ready, out_valid)

endmodule

bind morton_window_bounds_3d_unit mwb3d_checker u_mwb3d_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (point.valid),
	.in_ready   (point.ready),
	.out_valid  (bounds.valid),
	.out_ready  (bounds.ready),
	.window_min (bounds.window_min),
	.window_max (bounds.window_max)
);

`default_nettype wire
